>>> rtl/core/css_token_scanner_top_assert.svh
// Assertion macros shared by the token scanner RTL.
// No dependencies; included by the files that check their own logic.
`ifndef CSS_TOKEN_SCANNER_TOP_ASSERT_SVH
`define CSS_TOKEN_SCANNER_TOP_ASSERT_SVH

// check that cond implies result in the same cycle
`define CTS_ASSERT_IMPLY(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (result)) \
      else $error("css token scanner: same-cycle check failed");

// check that cond implies result in the next cycle
`define CTS_ASSERT_NEXT(label, clk, rst, cond, result) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error("css token scanner: next-cycle check failed");

`endif

>>> rtl/core/cts_pkg.sv
// Shared types, codes and the byte class table of the token scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package cts_pkg;

   localparam int TOKEN_W          = 16;
   localparam int KIND_W           = 4;
   localparam int STREAM_BYTES_DEF = 65536;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [3:0]        class_type;

   localparam kind_type KIND_OPEN   = 4'd0;
   localparam kind_type KIND_CLOSE  = 4'd1;
   localparam kind_type KIND_COLON  = 4'd2;
   localparam kind_type KIND_SEMI   = 4'd3;
   localparam kind_type KIND_COMMA  = 4'd4;
   localparam kind_type KIND_AT     = 4'd5;
   localparam kind_type KIND_INT    = 4'd6;
   localparam kind_type KIND_IDENT  = 4'd7;
   localparam kind_type KIND_STRING = 4'd8;
   localparam kind_type KIND_ERROR  = 4'd9;

   localparam class_type CL_ERR    = 4'd0;
   localparam class_type CL_SPACE  = 4'd1;
   localparam class_type CL_OPEN   = 4'd2;
   localparam class_type CL_CLOSE  = 4'd3;
   localparam class_type CL_AT     = 4'd4;
   localparam class_type CL_LETTER = 4'd5;
   localparam class_type CL_DIGIT  = 4'd6;
   localparam class_type CL_COLON  = 4'd7;
   localparam class_type CL_SEMI   = 4'd8;
   localparam class_type CL_QUOTE  = 4'd9;
   localparam class_type CL_HYPHEN = 4'd10;
   localparam class_type CL_SLASH  = 4'd11;
   localparam class_type CL_COMMA  = 4'd12;

   typedef struct packed {
      kind_type             kind;
      logic [TOKEN_W-1:0]   start;
      logic [TOKEN_W-1:0]   length;
   } tok_type;

   // one queue entry: the tokens caused by one byte, one or two
   typedef struct packed {
      logic    two;
      tok_type first;
      tok_type second;
   } rec_type;

   function automatic class_type byte_class(input logic [7:0] b);
      class_type c;
      unique case (b) inside
         8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: c = CL_SPACE;
         8'h7B:                                    c = CL_OPEN;
         8'h7D:                                    c = CL_CLOSE;
         8'h40:                                    c = CL_AT;
         [8'h41:8'h5A], [8'h61:8'h7A]:             c = CL_LETTER;
         [8'h30:8'h39]:                            c = CL_DIGIT;
         8'h3A:                                    c = CL_COLON;
         8'h3B:                                    c = CL_SEMI;
         8'h27:                                    c = CL_QUOTE;
         8'h2D:                                    c = CL_HYPHEN;
         8'h2F:                                    c = CL_SLASH;
         8'h2C:                                    c = CL_COMMA;
         default:                                  c = CL_ERR;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/css_token_scanner_top.sv
// Channel   Direction  Handshake        Word
// req_      in         push / full      data_byte, end_of_data
// rsp_      out        pop / empty      token_kind, token_start, token_length, last_of_run
//
// One byte is taken per cycle while the record queue has room; results pass through
// the record queue and the output register. A byte that causes two tokens gives two
// words at the output register in turn, so sustained input rate follows the
// output rate once the queue (QUEUE_DEPTH records) fills. Reset is synchronous,
// with no clearing pass. A stalled result side backs up through the queue to full;
// the front end holds its scan state until push is taken.
// Depends on cts_pkg, cts_front, cts_queue and cts_back.
`default_nettype none

module css_token_scanner_top #(
   parameter int STREAM_BYTES = cts_pkg::STREAM_BYTES_DEF,
   parameter int QUEUE_DEPTH  = cts_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_end_of_data,
   input  wire logic                          req_push,
   output logic                               req_full,
   output logic [cts_pkg::KIND_W-1:0]         rsp_token_kind,
   output logic [cts_pkg::TOKEN_W-1:0]        rsp_token_start,
   output logic [cts_pkg::TOKEN_W-1:0]        rsp_token_length,
   output logic                               rsp_last_of_run,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop
);
   import cts_pkg::*;

   rec_type   front_rec, q_data;
   logic      front_valid, accept, q_full, q_empty, q_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   cts_front #(
      .STREAM_BYTES(STREAM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_data (req_end_of_data),
      .rec         (front_rec),
      .rec_valid   (front_valid)
   );

   cts_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && front_valid),
      .push_data (front_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   cts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_data           (q_data),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

endmodule

`default_nettype wire

>>> rtl/core/cts_front.sv
// Front end: classifies each byte, tracks the scan mode and builds token records.
// Depends on cts_pkg and the assertion macro header.
`default_nettype none
`include "css_token_scanner_top_assert.svh"

module cts_front #(
   parameter int STREAM_BYTES = cts_pkg::STREAM_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_data,
   output cts_pkg::rec_type      rec,
   output logic                  rec_valid
);
   import cts_pkg::*;

   localparam int PW = $clog2(STREAM_BYTES);

   typedef enum logic [2:0] {
      M_IDLE, M_AT, M_INT, M_IDENT, M_STR, M_SLASH, M_COMMENT
   } mode_type;

   mode_type         mode_ff, mode_in, mid_mode, st_mode;
   logic [PW-1:0]    begin_ff, begin_in, mid_begin, st_begin;
   logic [PW-1:0]    pos_ff, pos_in, nxt;
   logic             star_ff, star_in, mid_star;
   class_type        cls;
   logic             st_emit, st_sets, use_st;
   tok_type          st_tok, a_tok, c_tok;
   logic             a_v, b_v, c_v;
   logic [PW-1:0]    span_pos, span_end;

   function automatic logic [PW-1:0] span(input logic [PW-1:0] from, input logic [PW-1:0] upto);
      logic [PW:0] diff;
      diff = {1'b0, upto} - {1'b0, from};
      if (diff[PW]) begin
         diff = diff + (PW+1)'(STREAM_BYTES);
      end
      return diff[PW-1:0];
   endfunction

   function automatic tok_type mk(input kind_type k, input logic [PW-1:0] s,
                                  input logic [PW-1:0] l);
      tok_type t;
      t.kind   = k;
      t.start  = TOKEN_W'(s);
      t.length = TOKEN_W'(l);
      return t;
   endfunction

   assign cls      = byte_class(data_byte);
   assign nxt      = (pos_ff == PW'(STREAM_BYTES - 1)) ? '0 : pos_ff + PW'(1);
   assign span_pos = span(begin_ff, pos_ff);

   // token that this byte starts when nothing is pending
   always_comb begin
      st_emit  = 1'b0;
      st_sets  = 1'b0;
      st_mode  = M_IDLE;
      st_begin = pos_ff;
      st_tok   = mk(KIND_ERROR, pos_ff, PW'(1));
      unique case (cls)
         CL_SPACE: ;
         CL_OPEN: begin
            st_emit = 1'b1;
            st_tok  = mk(KIND_OPEN, pos_ff, '0);
         end
         CL_CLOSE: begin
            st_emit = 1'b1;
            st_tok  = mk(KIND_CLOSE, pos_ff, '0);
         end
         CL_COLON: begin
            st_emit = 1'b1;
            st_tok  = mk(KIND_COLON, pos_ff, '0);
         end
         CL_SEMI: begin
            st_emit = 1'b1;
            st_tok  = mk(KIND_SEMI, pos_ff, '0);
         end
         CL_COMMA: begin
            st_emit = 1'b1;
            st_tok  = mk(KIND_COMMA, pos_ff, '0);
         end
         CL_AT: begin
            st_sets = 1'b1;
            st_mode = M_AT;
         end
         CL_DIGIT, CL_HYPHEN: begin
            st_sets = 1'b1;
            st_mode = M_INT;
         end
         CL_LETTER: begin
            st_sets = 1'b1;
            st_mode = M_IDENT;
         end
         CL_QUOTE: begin
            st_sets  = 1'b1;
            st_mode  = M_STR;
            st_begin = nxt;
         end
         CL_SLASH: begin
            st_sets = 1'b1;
            st_mode = M_SLASH;
         end
         default: st_emit = 1'b1;
      endcase
   end

   always_comb begin
      a_v       = 1'b0;
      a_tok     = mk(KIND_ERROR, begin_ff, PW'(1));
      use_st    = 1'b0;
      mid_mode  = mode_ff;
      mid_begin = begin_ff;
      mid_star  = star_ff;
      unique case (mode_ff)
         M_AT, M_IDENT: begin
            if (!(cls inside {CL_LETTER, CL_DIGIT, CL_HYPHEN})) begin
               a_v    = 1'b1;
               a_tok  = mk((mode_ff == M_AT) ? KIND_AT : KIND_IDENT, begin_ff, span_pos);
               use_st = 1'b1;
            end
         end
         M_INT: begin
            if (cls != CL_DIGIT) begin
               a_v    = 1'b1;
               a_tok  = mk(KIND_INT, begin_ff, span_pos);
               use_st = 1'b1;
            end
         end
         M_STR: begin
            if (cls == CL_QUOTE) begin
               a_v      = 1'b1;
               a_tok    = mk(KIND_STRING, begin_ff, span_pos);
               mid_mode = M_IDLE;
            end
         end
         M_SLASH: begin
            if (data_byte == CHAR_STAR) begin
               mid_mode = M_COMMENT;
               mid_star = 1'b0;
            end else begin
               a_v    = 1'b1;
               use_st = 1'b1;
            end
         end
         M_COMMENT: begin
            if (star_ff && data_byte == CHAR_SLASH) begin
               mid_mode = M_IDLE;
               mid_star = 1'b0;
            end else begin
               mid_star = (data_byte == CHAR_STAR);
            end
         end
         default: use_st = 1'b1;
      endcase
      if (use_st) begin
         mid_mode = st_mode;
         if (st_sets) begin
            mid_begin = st_begin;
         end
      end
   end

   assign b_v      = use_st && st_emit;
   assign span_end = span(mid_begin, nxt);

   // flush at end of stream
   always_comb begin
      c_v   = 1'b0;
      c_tok = mk(KIND_ERROR, mid_begin, PW'(1));
      if (end_of_data) begin
         unique case (mid_mode)
            M_AT: begin
               c_v   = 1'b1;
               c_tok = mk(KIND_AT, mid_begin, span_end);
            end
            M_INT: begin
               c_v   = 1'b1;
               c_tok = mk(KIND_INT, mid_begin, span_end);
            end
            M_IDENT: begin
               c_v   = 1'b1;
               c_tok = mk(KIND_IDENT, mid_begin, span_end);
            end
            M_STR: begin
               c_v   = 1'b1;
               c_tok = mk(KIND_ERROR, mid_begin, span_end);
            end
            M_SLASH: c_v = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      rec.first  = a_v ? a_tok : (b_v ? st_tok : c_tok);
      rec.second = (a_v && b_v) ? st_tok : c_tok;
      rec.two    = ($countones({a_v, b_v, c_v}) > 1);
      rec_valid  = a_v || b_v || c_v;
   end

   always_comb begin
      if (end_of_data) begin
         mode_in  = M_IDLE;
         begin_in = '0;
         pos_in   = '0;
         star_in  = 1'b0;
      end else begin
         mode_in  = mid_mode;
         begin_in = mid_begin;
         pos_in   = nxt;
         star_in  = mid_star;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         star_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         star_ff  <= star_in;
      end
   end

   `CTS_ASSERT_IMPLY(a_star_only_in_comment, clock, reset, star_ff, mode_ff == M_COMMENT)
   `CTS_ASSERT_NEXT(a_stream_end_resets, clock, reset, accept && end_of_data,
                    mode_ff == M_IDLE && pos_ff == '0)

endmodule

`default_nettype wire

>>> rtl/core/cts_queue.sv
// Short queue of token records between the front and back ends.
// Depends on cts_pkg and the assertion macro header.
`default_nettype none
`include "css_token_scanner_top_assert.svh"

module cts_queue #(
   parameter int DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cts_pkg::rec_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output cts_pkg::rec_type       pop_data,
   output logic                   empty
);
   import cts_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rec_type          entry_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in    = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      rd_in    = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_in;
         end
         if (do_pop) begin
            rd_ff <= rd_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   `CTS_ASSERT_NEXT(a_push_not_empty, clock, reset, push && !full, !empty)

endmodule

`default_nettype wire

>>> rtl/core/cts_back.sv
// Back end: splits queued records into single tokens and holds the result word.
// Depends on cts_pkg and the assertion macro header.
`default_nettype none
`include "css_token_scanner_top_assert.svh"

module cts_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cts_pkg::rec_type              q_data,
   input  wire logic                          q_empty,
   output logic                               q_pop,
   output logic [cts_pkg::KIND_W-1:0]         rsp_token_kind,
   output logic [cts_pkg::TOKEN_W-1:0]        rsp_token_start,
   output logic [cts_pkg::TOKEN_W-1:0]        rsp_token_length,
   output logic                               rsp_last_of_run,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop
);
   import cts_pkg::*;

   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   tok_type    tok_ff, cur;
   logic       last_ff, is_last, load, taken;

   assign taken   = rsp_pop && valid_ff;
   assign load    = !q_empty && (!valid_ff || taken);
   assign cur     = sel_ff ? q_data.second : q_data.first;
   assign is_last = sel_ff || !q_data.two;
   assign q_pop   = load && is_last;

   always_comb begin
      sel_in   = load ? !is_last : sel_ff;
      valid_in = load ? 1'b1 : (valid_ff && !taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= cur;
         last_ff <= is_last;
      end
   end

   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_start  = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_last_of_run  = last_ff;
   assign rsp_empty        = !valid_ff;

   `CTS_ASSERT_IMPLY(a_half_record_queued, clock, reset, sel_ff, !q_empty && q_data.two)

endmodule

`default_nettype wire

>>> verif/css_token_scanner_top_tb.sv
// Testbench for css_token_scanner_top: drives byte streams through the push/full
// side and checks every token word against its own scan-state predictor.
// Depends on cts_pkg and the css_token_scanner_top RTL.
`default_nettype none

module css_token_scanner_top_tb;
   import cts_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_AT, SCAN_INT, SCAN_IDENT, SCAN_STR, SCAN_SLASH, SCAN_COMMENT
   } scan_mode_type;

   typedef struct {
      logic [7:0] data;
      logic       eod;
      logic       drain;
   } stream_word_type;

   typedef struct {
      kind_type           kind;
      logic [TOKEN_W-1:0] start;
      logic [TOKEN_W-1:0] length;
      logic               last;
   } token_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_end_of_data = 1'b0;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [KIND_W-1:0]  rsp_token_kind;
   logic [TOKEN_W-1:0] rsp_token_start;
   logic [TOKEN_W-1:0] rsp_token_length;
   logic               rsp_last_of_run;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;

   css_token_scanner_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

   always #10 clock = ~clock;

   stream_word_type bytes_pending[$];
   token_type       tokens_due[$];
   token_type       run_tokens[$];
   stream_word_type next_word;
   int           bytes_planned = 0;
   int           bytes_taken = 0;
   int           fail_count = 0;
   int unsigned  send_gap = 0;
   int unsigned  pop_stall = 0;
   logic         word_taken = 1'b0;
   logic         hold_next = 1'b0;

   scan_mode_type      scan_mode = SCAN_IDLE;
   logic [TOKEN_W-1:0] tok_begin = '0;
   logic [TOKEN_W-1:0] scan_pos = '0;
   logic               star_seen = 1'b0;

   function automatic class_type sort_byte(input logic [7:0] b);
      if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) return CL_SPACE;
      if (b == 8'h7B) return CL_OPEN;
      if (b == 8'h7D) return CL_CLOSE;
      if (b == 8'h40) return CL_AT;
      if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) return CL_LETTER;
      if (b >= 8'h30 && b <= 8'h39) return CL_DIGIT;
      if (b == 8'h3A) return CL_COLON;
      if (b == 8'h3B) return CL_SEMI;
      if (b == 8'h27) return CL_QUOTE;
      if (b == 8'h2D) return CL_HYPHEN;
      if (b == CHAR_SLASH) return CL_SLASH;
      if (b == 8'h2C) return CL_COMMA;
      return CL_ERR;
   endfunction

   task automatic add_token(input kind_type kind, input logic [TOKEN_W-1:0] start,
                            input logic [TOKEN_W-1:0] length);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.last   = 1'b0;
      run_tokens.push_back(t);
   endtask

   task automatic open_token(input class_type cls, input logic [TOKEN_W-1:0] pos,
                             input logic [TOKEN_W-1:0] nxt);
      case (cls)
         CL_SPACE: ;
         CL_OPEN:  add_token(KIND_OPEN, pos, 16'd0);
         CL_CLOSE: add_token(KIND_CLOSE, pos, 16'd0);
         CL_COLON: add_token(KIND_COLON, pos, 16'd0);
         CL_SEMI:  add_token(KIND_SEMI, pos, 16'd0);
         CL_COMMA: add_token(KIND_COMMA, pos, 16'd0);
         CL_AT: begin
            scan_mode = SCAN_AT;
            tok_begin = pos;
         end
         CL_DIGIT, CL_HYPHEN: begin
            scan_mode = SCAN_INT;
            tok_begin = pos;
         end
         CL_LETTER: begin
            scan_mode = SCAN_IDENT;
            tok_begin = pos;
         end
         CL_QUOTE: begin
            scan_mode = SCAN_STR;
            tok_begin = nxt;
         end
         CL_SLASH: begin
            scan_mode = SCAN_SLASH;
            tok_begin = pos;
         end
         default: add_token(KIND_ERROR, pos, 16'd1);
      endcase
   endtask

   task automatic predict_tokens(input logic [7:0] b, input logic eod);
      class_type          cls;
      logic [TOKEN_W-1:0] pos;
      logic [TOKEN_W-1:0] nxt;
      cls = sort_byte(b);
      pos = scan_pos;
      nxt = scan_pos + 16'd1;
      run_tokens.delete();
      case (scan_mode)
         SCAN_AT, SCAN_IDENT: begin
            if (cls != CL_LETTER && cls != CL_DIGIT && cls != CL_HYPHEN) begin
               add_token(scan_mode == SCAN_AT ? KIND_AT : KIND_IDENT, tok_begin,
                         pos - tok_begin);
               scan_mode = SCAN_IDLE;
               open_token(cls, pos, nxt);
            end
         end
         SCAN_INT: begin
            if (cls != CL_DIGIT) begin
               add_token(KIND_INT, tok_begin, pos - tok_begin);
               scan_mode = SCAN_IDLE;
               open_token(cls, pos, nxt);
            end
         end
         SCAN_STR: begin
            if (cls == CL_QUOTE) begin
               add_token(KIND_STRING, tok_begin, pos - tok_begin);
               scan_mode = SCAN_IDLE;
            end
         end
         SCAN_SLASH: begin
            if (b == CHAR_STAR) begin
               scan_mode = SCAN_COMMENT;
               star_seen = 1'b0;
            end else begin
               add_token(KIND_ERROR, tok_begin, 16'd1);
               scan_mode = SCAN_IDLE;
               open_token(cls, pos, nxt);
            end
         end
         SCAN_COMMENT: begin
            if (star_seen && b == CHAR_SLASH) begin
               scan_mode = SCAN_IDLE;
               star_seen = 1'b0;
            end else begin
               star_seen = (b == CHAR_STAR);
            end
         end
         default: begin
            scan_mode = SCAN_IDLE;
            open_token(cls, pos, nxt);
         end
      endcase
      if (eod) begin
         case (scan_mode)
            SCAN_AT:    add_token(KIND_AT, tok_begin, nxt - tok_begin);
            SCAN_INT:   add_token(KIND_INT, tok_begin, nxt - tok_begin);
            SCAN_IDENT: add_token(KIND_IDENT, tok_begin, nxt - tok_begin);
            SCAN_STR:   add_token(KIND_ERROR, tok_begin, nxt - tok_begin);
            SCAN_SLASH: add_token(KIND_ERROR, tok_begin, 16'd1);
            default: ;
         endcase
         scan_mode = SCAN_IDLE;
         tok_begin = '0;
         scan_pos  = '0;
         star_seen = 1'b0;
      end else begin
         scan_pos = nxt;
      end
      if (run_tokens.size() != 0) run_tokens[run_tokens.size()-1].last = 1'b1;
      foreach (run_tokens[i]) tokens_due.push_back(run_tokens[i]);
   endtask

   task automatic check_token(input logic [KIND_W-1:0] kind,
                              input logic [TOKEN_W-1:0] start,
                              input logic [TOKEN_W-1:0] length, input logic last);
      token_type want;
      if (tokens_due.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("token scanner: unexpected word kind %0d start %0d length %0d last %0b",
                     kind, start, length, last);
      end else begin
         want = tokens_due.pop_front();
         if (want.kind !== kind || want.start !== start || want.length !== length ||
             want.last !== last) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"token scanner mismatch: expected kind %0d start %0d length %0d",
                         " last %0b, got kind %0d start %0d length %0d last %0b"},
                        want.kind, want.start, want.length, want.last,
                        kind, start, length, last);
         end
      end
   endtask

   function automatic bit idling_allowed();
      return bytes_pending.size() >= 120 && (bytes_pending.size() % 300) < 200;
   endfunction

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_push && !req_full;
         if (req_push && !req_full) begin
            predict_tokens(req_data_byte, req_end_of_data);
            bytes_taken++;
         end
         if (rsp_pop && !rsp_empty)
            check_token(rsp_token_kind, rsp_token_start, rsp_token_length, rsp_last_of_run);
      end
   end

   // byte driver: hold until taken, then idle or advance
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !word_taken) begin
         end else if (send_gap != 0) begin
            req_push <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (bytes_pending.size() != 0 && bytes_pending[0].drain &&
                      tokens_due.size() != 0) begin
            req_push <= 1'b0;
         end else if (bytes_pending.size() != 0) begin
            next_word = bytes_pending.pop_front();
            req_data_byte   <= next_word.data;
            req_end_of_data <= next_word.eod;
            req_push        <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 19);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // token receiver with random stall bursts
   always @(negedge clock) begin
      if (!reset) begin
         if (pop_stall != 0) begin
            rsp_pop   <= 1'b0;
            pop_stall <= pop_stall - 1;
         end else begin
            rsp_pop <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0)
               pop_stall <= $urandom_range(1, 19);
         end
      end
   end

   task automatic add_byte(input logic [7:0] b);
      stream_word_type w;
      w.data  = b;
      w.eod   = 1'b0;
      w.drain = hold_next;
      hold_next = 1'b0;
      bytes_pending.push_back(w);
      bytes_planned++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic end_stream();
      bytes_pending[bytes_pending.size()-1].eod = 1'b1;
   endtask

   function automatic logic [7:0] rand_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'h41 + r[7:0] : 8'h61 + r[7:0] - 8'd26;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_name_byte();
      case ($urandom_range(0, 2))
         0:       return rand_letter();
         1:       return rand_digit();
         default: return 8'h2D;
      endcase
   endfunction

   task automatic add_random_token();
      string      punct;
      logic [7:0] b;
      int         n;
      punct = "{}:;,";
      case ($urandom_range(0, 19))
         0, 1: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               b = ($urandom_range(0, 6) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(0, 4));
               add_byte(b);
            end
         end
         2, 3, 4: add_byte(punct[$urandom_range(0, 4)]);
         5: begin
            add_byte(8'h40);
            n = $urandom_range(0, 5);
            repeat (n) add_byte(rand_name_byte());
         end
         6, 7, 19: begin
            add_byte(($urandom_range(0, 3) == 0) ? 8'h2D : rand_digit());
            n = $urandom_range(0, 5);
            repeat (n) add_byte(rand_digit());
         end
         8, 9, 10, 18: begin
            add_byte(rand_letter());
            n = $urandom_range(0, 6);
            repeat (n) add_byte(rand_name_byte());
         end
         11, 12: begin
            add_byte(8'h27);
            n = $urandom_range(0, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == 8'h27) b = 8'h22;
               add_byte(b);
            end
            if ($urandom_range(0, 7) != 0) add_byte(8'h27);
         end
         13: begin
            add_byte(CHAR_SLASH);
            add_byte(CHAR_STAR);
            n = $urandom_range(0, 6);
            repeat (n) add_byte(($urandom_range(0, 2) == 0) ? CHAR_STAR :
                                8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) != 0) begin
               add_byte(CHAR_STAR);
               add_byte(CHAR_SLASH);
            end
         end
         14: begin
            add_byte(CHAR_SLASH);
            add_byte(8'($urandom_range(0, 255)));
         end
         15: add_byte(($urandom_range(0, 3) == 0) ? 8'h22 : 8'($urandom_range(128, 255)));
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin
      int n;
      // punctuation, at-keyword cut by a semicolon, comment opened by the same star
      add_text("{@x-;/*/*//a,'\"'\"");
      add_byte(8'h80);
      add_byte(8'hFF);
      add_text(":\t-7}");
      end_stream();
      add_text("'b");
      end_stream();
      add_byte(CHAR_SLASH);
      end_stream();
      add_byte(8'h39);
      end_stream();
      hold_next = 1'b1;

      while (bytes_planned < 1030) begin
         n = $urandom_range(1, 24);
         repeat (n) add_random_token();
         if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(0, 255)));
         end_stream();
         if ($urandom_range(0, 11) == 0) hold_next = 1'b1;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken != bytes_planned) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (fail_count == 0)
         $display("css_token_scanner_top_tb: clean");
      else
         $display("css_token_scanner_top_tb: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("css_token_scanner_top_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_front.sv
rtl/core/cts_queue.sv
rtl/core/cts_back.sv
rtl/core/css_token_scanner_top.sv
verif/css_token_scanner_top_tb.sv
